// ===== sv/word_wrap_max_window_unit_defines.svh =====
// Assertion macros for the word wrap window unit.
`ifndef WORD_WRAP_MAX_WINDOW_UNIT_DEFINES_SVH
`define WORD_WRAP_MAX_WINDOW_UNIT_DEFINES_SVH

// Checks an implication on every rising edge outside reset.
`define WWMW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent, on every rising edge outside reset.
`define WWMW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/wwmw_pkg.sv =====
// Shared constants for the word wrap window unit.
`timescale 1ns / 1ps
package wwmw_pkg;
    localparam int MAX_WORDS = 4096;
    localparam int LEN_BITS  = 16;
    localparam int IDX_W     = $clog2(MAX_WORDS + 1);
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CFG_W     = 16;
    localparam int SUM_W     = LEN_BITS + 2;
    localparam int ROUNDS    = 16;
    localparam int ROUND_W   = $clog2(ROUNDS);
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_ROW_COUNT  = 1'b1;
endpackage

// ===== sv/word_wrap_max_window_unit.sv =====
// Top level: greedy word wrap tables and best window search over a stored text.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+----------------------------------
//  words    | in        | i_valid / o_stall    | i_word_length, i_last_word
//  result   | out       | o_valid / i_stall    | o_best_start, o_word_count, o_overflow
//  config   | in        | i_cfg_we             | i_cfg_addr, i_cfg_data
//
// Words are taken one per cycle until the last one; then the unit computes.
// The line pass places words from each start word; then come the 16 lifting rounds, where a round
// with its row bit set adds a reach step, and last the scan over all start words.
// All tables sit in single-read-port memories.
// Reset is synchronous and active low; memories are not cleared.
// A stalled result holds; the next text may arrive while it waits.
`timescale 1ns / 1ps
`include "word_wrap_max_window_unit_defines.svh"
module word_wrap_max_window_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [15:0]                i_word_length,
    input  logic                       i_last_word,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [11:0]                o_best_start,
    output logic [12:0]                o_word_count,
    output logic                       o_overflow,
    input  logic                       i_cfg_we,
    input  logic                       i_cfg_addr,
    input  logic [wwmw_pkg::CFG_W-1:0] i_cfg_data
);
    import wwmw_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_NX_LOOP, S_NX_CMP, S_NX_FIN, S_NX_SUB, S_NX_END,
        S_RA, S_RB, S_RC, S_JA, S_JB, S_JC, S_SA, S_SB, S_OUT
    } t_state;

    logic [LEN_BITS-1:0] mem_len   [MAX_WORDS];
    logic [IDX_W-1:0]    mem_jump  [MAX_WORDS+1];
    logic [IDX_W-1:0]    mem_reach [MAX_WORDS];

    t_state              r_state;
    logic [CFG_W-1:0]    r_width, r_rows;
    logic [IDX_W-1:0]    r_cnt, r_s, r_e, r_i, r_best, r_best_cnt;
    logic [LEN_BITS-1:0] r_used;
    logic [ROUND_W-1:0]  r_b;
    logic                r_init, r_ovf, r_o_valid;
    logic [11:0]         r_o_best;
    logic [12:0]         r_o_cnt;
    logic                r_o_ovf;

    logic [LEN_BITS-1:0] r_len_q;
    logic [IDX_W-1:0]    r_jump_q, r_reach_q;

    logic [ADDR_W-1:0]   len_raddr;
    logic [IDX_W-1:0]    jump_raddr, jump_waddr, jump_wdata, rb_ptr, s_inc, scan_c;
    logic                jump_we;
    logic [SUM_W-1:0]    add_sum;
    logic                in_acc;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;
    assign o_best_start = r_o_best;
    assign o_word_count = r_o_cnt;
    assign o_overflow   = r_o_ovf;

    assign s_inc   = r_s + 1'b1;
    assign rb_ptr  = r_init ? r_i : r_reach_q;
    assign scan_c  = r_init ? '0 : (r_reach_q - r_i);
    assign add_sum = SUM_W'(r_used) + SUM_W'(r_len_q) + SUM_W'(r_e != r_s);
    assign len_raddr = (r_state == S_NX_FIN) ? r_s[ADDR_W-1:0] : r_e[ADDR_W-1:0];

    always_comb begin
        case (r_state)
            S_JA:    jump_raddr = r_i;
            S_JB:    jump_raddr = r_jump_q;
            default: jump_raddr = rb_ptr;
        endcase
        jump_we    = 1'b0;
        jump_waddr = r_i;
        jump_wdata = r_jump_q;
        case (r_state)
            S_NX_FIN: begin
                jump_we    = 1'b1;
                jump_waddr = r_s;
                jump_wdata = r_e;
            end
            S_NX_END: begin
                jump_we    = 1'b1;
                jump_waddr = r_cnt;
                jump_wdata = r_cnt;
            end
            S_JC: begin
                jump_we = 1'b1;
            end
            default: begin
                jump_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (r_cnt < IDX_W'(MAX_WORDS))) begin
            mem_len[r_cnt[ADDR_W-1:0]] <= i_word_length[LEN_BITS-1:0];
        end
        r_len_q <= mem_len[len_raddr];
        if (jump_we) begin
            mem_jump[jump_waddr] <= jump_wdata;
        end
        r_jump_q <= mem_jump[jump_raddr];
        if (r_state == S_RC) begin
            mem_reach[r_i[ADDR_W-1:0]] <= r_jump_q;
        end
        r_reach_q <= mem_reach[r_i[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_width   <= CFG_W'(80);
            r_rows    <= CFG_W'(1);
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_LINE_WIDTH: r_width <= i_cfg_data;
                    CFG_ROW_COUNT:  r_rows  <= i_cfg_data;
                    default:        r_rows  <= r_rows;
                endcase
            end
            if (r_o_valid && !i_stall && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_cnt < IDX_W'(MAX_WORDS)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (i_last_word) begin
                            r_s     <= '0;
                            r_e     <= '0;
                            r_used  <= '0;
                            r_state <= S_NX_LOOP;
                        end
                    end
                end
                S_NX_LOOP: begin
                    if (r_cnt == '0) begin
                        r_state <= S_NX_END;
                    end else if (r_e < r_cnt) begin
                        r_state <= S_NX_CMP;
                    end else begin
                        r_state <= S_NX_FIN;
                    end
                end
                S_NX_CMP: begin
                    if (add_sum > SUM_W'(r_width)) begin
                        r_state <= S_NX_FIN;
                    end else begin
                        r_used  <= add_sum[LEN_BITS-1:0];
                        r_e     <= r_e + 1'b1;
                        r_state <= S_NX_LOOP;
                    end
                end
                S_NX_FIN, S_NX_SUB: begin
                    if ((r_state == S_NX_FIN) && (r_e > s_inc)) begin
                        r_state <= S_NX_SUB;
                    end else begin
                        if (r_state == S_NX_SUB) begin
                            r_used <= LEN_BITS'(SUM_W'(r_used) - SUM_W'(r_len_q) - 1'b1);
                        end else if (r_e == s_inc) begin
                            r_used <= '0;
                        end
                        r_s <= s_inc;
                        if (s_inc == r_cnt) begin
                            r_state <= S_NX_END;
                        end else begin
                            if (r_e < s_inc) begin
                                r_e    <= s_inc;
                                r_used <= '0;
                            end
                            r_state <= S_NX_LOOP;
                        end
                    end
                end
                S_NX_END: begin
                    r_i    <= '0;
                    r_b    <= '0;
                    r_init <= 1'b1;
                    r_best <= '0;
                    r_best_cnt <= '0;
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else if (r_rows[0]) begin
                        r_state <= S_RA;
                    end else begin
                        r_state <= S_JA;
                    end
                end
                S_RA: r_state <= S_RB;
                S_RB: r_state <= S_RC;
                S_RC: begin
                    if (r_i + 1'b1 == r_cnt) begin
                        r_i     <= '0;
                        r_init  <= 1'b0;
                        r_state <= S_JA;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RA;
                    end
                end
                S_JA: r_state <= S_JB;
                S_JB: r_state <= S_JC;
                S_JC: begin
                    if (r_i + 1'b1 == r_cnt) begin
                        r_i <= '0;
                        if (r_b == ROUND_W'(ROUNDS - 1)) begin
                            r_state <= S_SA;
                        end else begin
                            r_b <= r_b + 1'b1;
                            r_state <= r_rows[r_b + 1'b1] ? S_RA : S_JA;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_JA;
                    end
                end
                S_SA: r_state <= S_SB;
                S_SB: begin
                    if ((r_i == '0) || (scan_c > r_best_cnt)) begin
                        r_best     <= r_i;
                        r_best_cnt <= scan_c;
                    end
                    if (r_i + 1'b1 == r_cnt) begin
                        r_state <= S_OUT;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_SA;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || !i_stall) begin
                        r_o_valid <= 1'b1;
                        r_o_best  <= r_best[11:0];
                        r_o_cnt   <= 13'(r_best_cnt);
                        r_o_ovf   <= r_ovf;
                        r_cnt     <= '0;
                        r_ovf     <= 1'b0;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `WWMW_ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= IDX_W'(MAX_WORDS), "word count beyond capacity")
    `WWMW_ASSERT_NEXT(a_last_stalls, i_clk, i_rst_n, in_acc && i_last_word, o_stall, "input not stalled after last word")
    `WWMW_ASSERT_NEXT(a_out_load, i_clk, i_rst_n, (r_state == S_OUT) && !(r_o_valid && i_stall), o_valid && !o_stall, "result not presented")
    `WWMW_ASSERT_IMPL(a_window, i_clk, i_rst_n, r_state == S_SB, r_best_cnt <= r_cnt, "window longer than text")
endmodule
